// ----- hdl/izh_pkg.sv -----
package izh_pkg;

	typedef logic signed [31:0] word_t;

	localparam int QOne = 65536;
	localparam int CurrentGain = 200;
	localparam word_t WordMax = 32'sh7fffffff;
	localparam word_t WordMin = -32'sh80000000;
	localparam word_t CurLimitQ = 32'sd39321600;
	localparam word_t CurLimitNegQ = -32'sd39321600;
	localparam word_t QOneW = 32'sd65536;
	localparam word_t QOneNegW = -32'sd65536;
	// ceil(2^35 / 11), exact floor(n / 11) for any 32-bit n after >> 35
	localparam logic [31:0] DivMagic = 32'hBA2E8BA3;
	localparam int DivShift = 35;

	typedef enum logic [2:0] {
		REG_REST_VOLTAGE,
		REG_THRESHOLD_VOLTAGE,
		REG_QUAD_GAIN,
		REG_INPUT_GAIN,
		REG_RECOVERY_RATE,
		REG_RECOVERY_SENSITIVITY,
		REG_RESET_VOLTAGE,
		REG_RECOVERY_JUMP
	} reg_idx_t;

	typedef struct packed {
		word_t rest_voltage;
		word_t threshold_voltage;
		word_t quad_gain;
		word_t input_gain;
		word_t recovery_rate;
		word_t recovery_sensitivity;
		word_t reset_voltage;
		word_t recovery_jump;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		rest_voltage:         -32'sd4259840,
		threshold_voltage:    -32'sd2621440,
		quad_gain:            32'sd459,
		input_gain:           32'sd65,
		recovery_rate:        32'sd197,
		recovery_sensitivity: -32'sd131072,
		reset_voltage:        -32'sd3276800,
		recovery_jump:        32'sd6553600
	};

	// alu operand and destination selects
	typedef enum logic [2:0] {
		ASRC_ZERO, ASRC_V, ASRC_U, ASRC_I, ASRC_ACC, ASRC_P16, ASRC_PRAW, ASRC_TEN
	} asrc_t;

	typedef enum logic [2:0] {
		BSRC_ZERO, BSRC_REST, BSRC_THR, BSRC_U, BSRC_P16, BSRC_P16_GATED, BSRC_I,
		BSRC_WEIGHT
	} bsrc_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_DV, DST_DTH, DST_TMP, DST_UNEW, DST_ACC, DST_NEG, DST_CUR
	} dst_t;

	// multiplier operand selects
	typedef enum logic [2:0] {
		MA_I, MA_DV, MA_RB, MA_GIN, MA_RA, MA_KQ, MA_NEG
	} ma_t;

	typedef enum logic [2:0] {
		MB_C200, MB_DV, MB_TMP, MB_U, MB_DTH, MB_MAGIC
	} mb_t;

	typedef enum logic [1:0] {
		JMP_NEXT, JMP_ALWAYS, JMP_CUR_OOR
	} jmp_t;

	typedef enum logic [1:0] {
		FIN_NONE, FIN_DONE, FIN_COMMIT
	} fin_t;

	localparam int UcodeDepth = 15;
	localparam int PcW = $clog2(UcodeDepth);
	typedef logic [PcW-1:0] pc_t;

	localparam pc_t TickEntry = pc_t'(0);
	localparam pc_t DeliverEntry = pc_t'(12);
	localparam pc_t DeliverSkip = pc_t'(14);

	typedef struct packed {
		asrc_t a;
		bsrc_t b;
		logic  sub;
		dst_t  dst;
		logic  mul_en;
		ma_t   ma;
		mb_t   mb;
		jmp_t  jmp;
		pc_t   target;
		fin_t  fin;
	} uword_t;

	typedef struct packed {
		logic   step;
		uword_t word;
	} ctrl_t;

	typedef struct packed {
		logic cur_out_of_range;
	} status_t;

	typedef struct packed {
		logic  spike;
		word_t membrane_sample;
		word_t current_sample;
	} result_t;

	function automatic uword_t uw(input asrc_t a, input bsrc_t b, input logic sub,
			input dst_t dst, input logic mul_en, input ma_t ma, input mb_t mb,
			input jmp_t jmp, input pc_t target, input fin_t fin);
		uword_t w;
		w.a = a;
		w.b = b;
		w.sub = sub;
		w.dst = dst;
		w.mul_en = mul_en;
		w.ma = ma;
		w.mb = mb;
		w.jmp = jmp;
		w.target = target;
		w.fin = fin;
		return w;
	endfunction

	// control store: tick program from TickEntry, deliver program from DeliverEntry
	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		unique case (pc)
			pc_t'(0): w = uw(ASRC_V, BSRC_REST, 1'b1, DST_DV, 1'b1, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(1): w = uw(ASRC_PRAW, BSRC_ZERO, 1'b0, DST_TMP, 1'b1, MA_RB, MB_DV,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(2): w = uw(ASRC_P16, BSRC_U, 1'b1, DST_TMP, 1'b1, MA_GIN, MB_TMP,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(3): w = uw(ASRC_V, BSRC_P16_GATED, 1'b0, DST_ACC, 1'b1, MA_RA, MB_TMP,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(4): w = uw(ASRC_U, BSRC_P16, 1'b0, DST_UNEW, 1'b1, MA_GIN, MB_U,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(5): w = uw(ASRC_ACC, BSRC_P16, 1'b1, DST_ACC, 1'b0, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(6): w = uw(ASRC_V, BSRC_THR, 1'b1, DST_DTH, 1'b0, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(7): w = uw(ASRC_TEN, BSRC_I, 1'b1, DST_NEG, 1'b1, MA_DV, MB_DTH,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(8): w = uw(ASRC_P16, BSRC_ZERO, 1'b0, DST_DTH, 1'b0, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(9): w = uw(ASRC_ZERO, BSRC_ZERO, 1'b0, DST_NONE, 1'b1, MA_KQ, MB_DTH,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(10): w = uw(ASRC_ACC, BSRC_P16, 1'b0, DST_ACC, 1'b1, MA_NEG, MB_MAGIC,
				JMP_NEXT, TickEntry, FIN_NONE);
			pc_t'(11): w = uw(ASRC_ZERO, BSRC_ZERO, 1'b0, DST_NONE, 1'b0, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_COMMIT);
			pc_t'(12): w = uw(ASRC_ZERO, BSRC_ZERO, 1'b0, DST_NONE, 1'b0, MA_I, MB_C200,
				JMP_CUR_OOR, DeliverSkip, FIN_NONE);
			pc_t'(13): w = uw(ASRC_I, BSRC_WEIGHT, 1'b0, DST_CUR, 1'b0, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_DONE);
			default: w = uw(ASRC_ZERO, BSRC_ZERO, 1'b0, DST_NONE, 1'b0, MA_I, MB_C200,
				JMP_NEXT, TickEntry, FIN_DONE);
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/izh_sequencer.sv -----
module izh_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	input  logic              out_hold,
	input  izh_pkg::status_t  status,
	output logic              idle,
	output izh_pkg::ctrl_t    ctrl
);

	logic             busy_q;
	izh_pkg::pc_t     pc_q;
	izh_pkg::uword_t  word;
	logic             advance;
	logic             take;

	assign word = izh_pkg::ucode_rom(pc_q);
	// the commit step waits while the output register is still occupied
	assign advance = busy_q && !(word.fin == izh_pkg::FIN_COMMIT && out_hold);
	assign idle = !busy_q;
	assign ctrl.step = advance;
	assign ctrl.word = word;

	always_comb begin
		unique case (word.jmp)
			izh_pkg::JMP_NEXT:    take = 1'b0;
			izh_pkg::JMP_ALWAYS:  take = 1'b1;
			izh_pkg::JMP_CUR_OOR: take = status.cur_out_of_range;
			default:              take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= izh_pkg::TickEntry;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q <= command ? izh_pkg::TickEntry : izh_pkg::DeliverEntry;
			end
		end else if (advance) begin
			if (word.fin != izh_pkg::FIN_NONE) begin
				busy_q <= 1'b0;
			end else if (take) begin
				pc_q <= word.target;
			end else begin
				pc_q <= pc_q + izh_pkg::pc_t'(1);
			end
		end
	end

endmodule

// ----- hdl/izh_datapath.sv -----
module izh_datapath #(
	parameter int REFRACTORY_STEPS = 20,
	parameter int PEAK_MV = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  izh_pkg::ctrl_t      ctrl,
	input  izh_pkg::cfg_t       cfg,
	input  logic                load,
	input  logic signed [31:0]  weight,
	output izh_pkg::status_t    status,
	output izh_pkg::result_t    result
);

	localparam logic [7:0] RefrLoad = 8'(REFRACTORY_STEPS);
	localparam logic signed [31:0] PeakQ = 32'(PEAK_MV * izh_pkg::QOne);
	localparam int AccW = 36;
	localparam int MulW = 33;
	localparam int ProdW = 2 * MulW;

	function automatic izh_pkg::word_t sat_acc(input logic signed [AccW-1:0] x);
		if (x > AccW'(izh_pkg::WordMax)) begin
			return izh_pkg::WordMax;
		end else if (x < AccW'(izh_pkg::WordMin)) begin
			return izh_pkg::WordMin;
		end
		return x[31:0];
	endfunction

	function automatic izh_pkg::word_t sat_prod(input logic signed [ProdW-1:0] x);
		if (x > ProdW'(izh_pkg::WordMax)) begin
			return izh_pkg::WordMax;
		end else if (x < ProdW'(izh_pkg::WordMin)) begin
			return izh_pkg::WordMin;
		end
		return x[31:0];
	endfunction

	// architectural state
	izh_pkg::word_t  membrane_q;
	izh_pkg::word_t  recovery_q;
	izh_pkg::word_t  current_q;
	logic [7:0]      timer_q;

	// scratch registers of the tick program
	izh_pkg::word_t           weight_q;
	izh_pkg::word_t           dv_q;
	izh_pkg::word_t           dth_q;
	izh_pkg::word_t           tmp_q;
	izh_pkg::word_t           unew_q;
	logic signed [AccW-1:0]   acc_q;
	logic [31:0]              neg_q;
	logic signed [ProdW-1:0]  prod_q;

	izh_pkg::uword_t          w;
	logic                     commit;
	izh_pkg::word_t           p16;
	izh_pkg::word_t           praw;
	izh_pkg::word_t           q_div;
	logic signed [AccW-1:0]   a_val;
	logic signed [AccW-1:0]   b_val;
	logic signed [AccW-1:0]   alu_sum;
	izh_pkg::word_t           alu_sat;
	logic signed [MulW-1:0]   mul_a;
	logic signed [MulW-1:0]   mul_b;
	logic signed [ProdW-1:0]  prod_d;

	izh_pkg::word_t  v_sat;
	izh_pkg::word_t  v_clamp;
	logic            spike;
	izh_pkg::word_t  u_jump;
	logic [7:0]      timer_load;
	logic [7:0]      timer_next;
	izh_pkg::word_t  cur_dec;
	izh_pkg::word_t  cur_next;

	assign w = ctrl.word;
	assign commit = ctrl.step && (w.fin == izh_pkg::FIN_COMMIT);

	assign p16 = sat_prod(prod_q >>> 16);
	assign praw = sat_prod(prod_q);
	assign q_div = {1'b0, prod_q[ProdW-1:izh_pkg::DivShift]};

	always_comb begin
		unique case (w.a)
			izh_pkg::ASRC_ZERO: a_val = '0;
			izh_pkg::ASRC_V:    a_val = AccW'(membrane_q);
			izh_pkg::ASRC_U:    a_val = AccW'(recovery_q);
			izh_pkg::ASRC_I:    a_val = AccW'(current_q);
			izh_pkg::ASRC_ACC:  a_val = acc_q;
			izh_pkg::ASRC_P16:  a_val = AccW'(p16);
			izh_pkg::ASRC_PRAW: a_val = AccW'(praw);
			izh_pkg::ASRC_TEN:  a_val = AccW'(10);
		endcase
	end

	always_comb begin
		unique case (w.b)
			izh_pkg::BSRC_ZERO:      b_val = '0;
			izh_pkg::BSRC_REST:      b_val = AccW'(cfg.rest_voltage);
			izh_pkg::BSRC_THR:       b_val = AccW'(cfg.threshold_voltage);
			izh_pkg::BSRC_U:         b_val = AccW'(recovery_q);
			izh_pkg::BSRC_P16:       b_val = AccW'(p16);
			// input current only counts outside the refractory period
			izh_pkg::BSRC_P16_GATED: b_val = (timer_q == 8'd0) ? AccW'(p16) : '0;
			izh_pkg::BSRC_I:         b_val = AccW'(current_q);
			izh_pkg::BSRC_WEIGHT:    b_val = AccW'(weight_q);
		endcase
	end

	assign alu_sum = w.sub ? (a_val - b_val) : (a_val + b_val);
	assign alu_sat = sat_acc(alu_sum);

	always_comb begin
		unique case (w.ma)
			izh_pkg::MA_I:   mul_a = MulW'(current_q);
			izh_pkg::MA_DV:  mul_a = MulW'(dv_q);
			izh_pkg::MA_RB:  mul_a = MulW'(cfg.recovery_sensitivity);
			izh_pkg::MA_GIN: mul_a = MulW'(cfg.input_gain);
			izh_pkg::MA_RA:  mul_a = MulW'(cfg.recovery_rate);
			izh_pkg::MA_KQ:  mul_a = MulW'(cfg.quad_gain);
			izh_pkg::MA_NEG: mul_a = {1'b0, neg_q};
			default:         mul_a = '0;
		endcase
	end

	always_comb begin
		unique case (w.mb)
			izh_pkg::MB_C200:  mul_b = MulW'(izh_pkg::CurrentGain);
			izh_pkg::MB_DV:    mul_b = MulW'(dv_q);
			izh_pkg::MB_TMP:   mul_b = MulW'(tmp_q);
			izh_pkg::MB_U:     mul_b = MulW'(recovery_q);
			izh_pkg::MB_DTH:   mul_b = MulW'(dth_q);
			izh_pkg::MB_MAGIC: mul_b = {1'b0, izh_pkg::DivMagic};
			default:           mul_b = '0;
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// end of tick: clamp, spike, refractory timer and current decay
	assign v_sat = sat_acc(acc_q);
	assign v_clamp = (v_sat < cfg.reset_voltage) ? cfg.reset_voltage : v_sat;
	assign spike = (v_clamp >= PeakQ);
	assign u_jump = sat_acc(AccW'(unew_q) + AccW'(cfg.recovery_jump));
	assign timer_load = spike ? RefrLoad : timer_q;
	assign timer_next = (timer_load != 8'd0) ? (timer_load - 8'd1) : 8'd0;

	always_comb begin
		if (current_q > 32'sd0) begin
			cur_dec = current_q >>> 1;
		end else if (current_q < 32'sd0) begin
			// -(10m / 11) = ceil(m / 11) - m, ceil taken as floor((m + 10) / 11)
			cur_dec = current_q + q_div;
		end else begin
			cur_dec = '0;
		end
		if (cur_dec <= izh_pkg::QOneW && cur_dec >= izh_pkg::QOneNegW) begin
			cur_next = '0;
		end else begin
			cur_next = cur_dec;
		end
	end

	assign status.cur_out_of_range = (current_q > izh_pkg::CurLimitQ)
		|| (current_q < izh_pkg::CurLimitNegQ);

	assign result.spike = spike;
	assign result.membrane_sample = v_sat;
	assign result.current_sample = current_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membrane_q <= izh_pkg::CfgReset.rest_voltage;
			recovery_q <= '0;
			current_q <= '0;
			timer_q <= '0;
		end else if (commit) begin
			membrane_q <= spike ? cfg.reset_voltage : v_clamp;
			recovery_q <= spike ? u_jump : unew_q;
			current_q <= cur_next;
			timer_q <= timer_next;
		end else if (ctrl.step && w.dst == izh_pkg::DST_CUR) begin
			current_q <= alu_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			weight_q <= weight;
		end
		if (ctrl.step && w.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctrl.step) begin
			unique case (w.dst)
				izh_pkg::DST_NONE: ;
				izh_pkg::DST_DV:   dv_q <= alu_sat;
				izh_pkg::DST_DTH:  dth_q <= alu_sat;
				izh_pkg::DST_TMP:  tmp_q <= alu_sat;
				izh_pkg::DST_UNEW: unew_q <= alu_sat;
				izh_pkg::DST_ACC:  acc_q <= alu_sum;
				izh_pkg::DST_NEG:  neg_q <= alu_sum[31:0];
				izh_pkg::DST_CUR:  ;
			endcase
		end
	end

endmodule

// ----- hdl/izhikevich_neuron_step.sv -----
// One Izhikevich neuron in signed Q16.16. A deliver item (command 0) adds its weight to the
// input current when that current lies within +/-600 and gives no result; a tick item
// (command 1) runs one Euler step and returns the spike flag with the membrane sample
// before the lower clamp and the current sample before decay. Items are processed one at
// a time by a 15-word microcode program driving one 33x33 multiplier and one adder: in_ready
// stays low from the transfer of an item until its program finishes, so no new item is taken
// before the last one is through; the last tick step waits while the previous result is still
// untaken. Configuration writes take effect on the next edge and belong in idle periods.
module izhikevich_neuron_step #(
	parameter int REFRACTORY_STEPS = 20,
	parameter int PEAK_MV = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic signed [31:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic signed [31:0]  weight,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                spike,
	output logic signed [31:0]  membrane_sample,
	output logic signed [31:0]  current_sample
);

	izh_pkg::cfg_t     cfg_q;
	izh_pkg::ctrl_t    ctrl;
	izh_pkg::status_t  status;
	izh_pkg::result_t  result;
	logic              idle;
	logic              in_xfer;
	logic              out_hold;
	logic              commit;
	logic              out_valid_q;
	logic              spike_q;
	izh_pkg::word_t    membrane_sample_q;
	izh_pkg::word_t    current_sample_q;

	assign in_ready = idle;
	assign in_xfer = in_valid && idle;
	assign out_hold = out_valid_q && !out_ready;
	assign commit = ctrl.step && (ctrl.word.fin == izh_pkg::FIN_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= izh_pkg::CfgReset;
		end else if (cfg_we) begin
			unique case (izh_pkg::reg_idx_t'(cfg_index))
				izh_pkg::REG_REST_VOLTAGE:         cfg_q.rest_voltage <= cfg_data;
				izh_pkg::REG_THRESHOLD_VOLTAGE:    cfg_q.threshold_voltage <= cfg_data;
				izh_pkg::REG_QUAD_GAIN:            cfg_q.quad_gain <= cfg_data;
				izh_pkg::REG_INPUT_GAIN:           cfg_q.input_gain <= cfg_data;
				izh_pkg::REG_RECOVERY_RATE:        cfg_q.recovery_rate <= cfg_data;
				izh_pkg::REG_RECOVERY_SENSITIVITY: cfg_q.recovery_sensitivity <= cfg_data;
				izh_pkg::REG_RESET_VOLTAGE:        cfg_q.reset_voltage <= cfg_data;
				izh_pkg::REG_RECOVERY_JUMP:        cfg_q.recovery_jump <= cfg_data;
			endcase
		end
	end

	izh_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.command  (command),
		.out_hold (out_hold),
		.status   (status),
		.idle     (idle),
		.ctrl     (ctrl)
	);

	izh_datapath #(
		.REFRACTORY_STEPS (REFRACTORY_STEPS),
		.PEAK_MV          (PEAK_MV)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg_q),
		.load   (in_xfer),
		.weight (weight),
		.status (status),
		.result (result)
	);

	// output register, refilled only once the previous result has been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			spike_q <= result.spike;
			membrane_sample_q <= result.membrane_sample;
			current_sample_q <= result.current_sample;
		end
	end

	assign out_valid = out_valid_q;
	assign spike = spike_q;
	assign membrane_sample = membrane_sample_q;
	assign current_sample = current_sample_q;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a previous item is still in work");

	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid || out_ready))
		else $error("result committed over an untaken result");

	a_deliver_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !command && !out_valid |=> !out_valid)
		else $error("deliver produced a result");

	a_commit_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !in_ready)
		else $error("commit step while the sequencer is idle");

endmodule
